### rtl/mfad_pkg.sv
// ----------------------------------------------------------------------------
// mfad_pkg: shared types and constants of the mode 5 frame decryptor
// Holds frame geometry, the AES S-box tables, status codes and the command
// and status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mfad_pkg;

    localparam int FRAME_MAX  = 256;
    localparam int HEADER_LEN = 15;
    localparam int POS_W      = $clog2(FRAME_MAX + 1);
    localparam logic [7:0] CHECK_BYTE = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FRAME_SHORT = 2'd1,
        ST_PAYLOAD_SHORT = 2'd2,
        ST_FRAME_LONG  = 2'd3
    } frame_status_t;

    // What an accepted byte does.
    typedef enum logic [1:0] {
        CLS_DROP   = 2'd0,
        CLS_SINGLE = 2'd1,
        CLS_BUFFER = 2'd2
    } item_cls_t;

    // Source of an emitted result.
    typedef enum logic [1:0] {
        EM_SINGLE = 2'd0,
        EM_BLOCK  = 2'd1,
        EM_FLUSH  = 2'd2,
        EM_DUMMY  = 2'd3
    } emit_sel_t;

    typedef struct packed {
        logic       accept;
        logic       aes_load;
        logic       aes_round;
        logic       aes_finish;
        logic [3:0] rk_idx;
        logic       emit;
        emit_sel_t  sel;
        logic [3:0] idx;
        logic       end_frame;
        logic       clear;
    } mfad_cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic       in_last;
        item_cls_t  cls;
        logic       blk_full;
        logic       fill_nz;
        logic [3:0] fill_last;
        logic       last;
        logic       out_free;
        logic       key_ready;
    } mfad_sts_t;

    localparam logic [2047:0] SBOX_V = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_V = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX_V[(8'd255 - a) * 8 +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        return INV_SBOX_V[(8'd255 - a) * 8 +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

endpackage

### rtl/mfad_keyexp.sv
// ----------------------------------------------------------------------------
// mfad_keyexp: AES-128 key register and round key expansion
// Holds the key, expands it one round key per cycle after each key write
// and after reset, and serves one round key at a time.
// ----------------------------------------------------------------------------
module mfad_keyexp
    import mfad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic [3:0]   rk_idx,
    output logic [127:0] rk_word,
    output logic         key_ready
);

    logic [63:0]  key_hi_reg;
    logic [63:0]  key_lo_reg;
    logic         start_reg;
    logic         busy_reg;
    logic [3:0]   step_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] cur_reg;
    logic [127:0] rk_mem [11];
    logic [127:0] next_key;
    logic [31:0]  t_word;

    always_comb
    begin
        t_word = {sbox(cur_reg[23:16]) ^ rcon_reg, sbox(cur_reg[15:8]),
                  sbox(cur_reg[7:0]), sbox(cur_reg[31:24])};
        next_key[127:96] = cur_reg[127:96] ^ t_word;
        next_key[95:64]  = cur_reg[95:64] ^ next_key[127:96];
        next_key[63:32]  = cur_reg[63:32] ^ next_key[95:64];
        next_key[31:0]   = cur_reg[31:0] ^ next_key[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            start_reg  <= 1'b1;
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            rcon_reg   <= 8'h01;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index)
                    key_lo_reg <= cfg_data;
                else
                    key_hi_reg <= cfg_data;
                start_reg <= 1'b1;
            end
            else if (start_reg)
            begin
                start_reg <= 1'b0;
                busy_reg  <= 1'b1;
                step_reg  <= 4'd1;
                rcon_reg  <= 8'h01;
            end
            else if (busy_reg)
            begin
                rcon_reg <= xtime(rcon_reg);
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd10)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cfg_we && start_reg)
        begin
            cur_reg   <= {key_hi_reg, key_lo_reg};
            rk_mem[0] <= {key_hi_reg, key_lo_reg};
        end
        else if (!cfg_we && busy_reg)
        begin
            cur_reg          <= next_key;
            rk_mem[step_reg] <= next_key;
        end
    end

    assign rk_word   = rk_mem[rk_idx];
    assign key_ready = !start_reg && !busy_reg && !cfg_we;

endmodule

### rtl/mfad_datapath.sv
// ----------------------------------------------------------------------------
// mfad_datapath: frame bookkeeping, block buffer, AES round unit and output
// Classifies each byte, keeps the CBC chain, runs one inverse AES round per
// command and holds the output register.
// ----------------------------------------------------------------------------
module mfad_datapath
    import mfad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mfad_cmd_t    cmd,
    output mfad_sts_t    sts,
    input  logic         in_valid,
    input  logic [7:0]   frame_byte,
    input  logic [15:0]  tpl_config,
    input  logic         last_byte,
    input  logic [127:0] rk_word,
    input  logic         key_ready,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   out_byte,
    output logic         was_decrypted,
    output logic         frame_end,
    output logic [1:0]   status,
    output logic         check_bytes_ok
);

    logic [POS_W-1:0] pos_reg;
    logic [3:0]       limit_reg;
    logic [4:0]       done_reg;
    logic [3:0]       fill_reg;
    logic             check_reg;
    logic             ovf_reg;
    logic             last_reg;
    logic [7:0]       byte_reg;
    logic [127:0]     chain_reg;
    logic [127:0]     st_reg;
    logic [7:0]       buf_mem [16];
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_dec_reg;
    logic             out_end_reg;
    logic [1:0]       out_status_reg;
    logic             out_check_reg;

    logic [3:0]       lim_eff;
    item_cls_t        cls;
    logic [127:0]     buf_block;
    logic [127:0]     plain;
    frame_status_t    fst;
    logic [7:0]       em_byte;
    logic             em_dec;

    function automatic logic [127:0] inv_round(input logic [127:0] s,
                                              input logic [127:0] k,
                                              input logic mix);
        logic [7:0] a [16];
        logic [7:0] t [16];
        logic [7:0] x2, x4, x8;
        logic [7:0] m [4][4];
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            a[i] = s[127 - 8 * i -: 8];
        for (int c = 0; c < 4; c++)
            for (int row = 0; row < 4; row++)
                t[row + 4 * c] = inv_sbox(a[row + 4 * ((c + 4 - row) & 3)])
                                 ^ k[127 - 8 * (row + 4 * c) -: 8];
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                x2 = xtime(t[4 * c + j]);
                x4 = xtime(x2);
                x8 = xtime(x4);
                m[j][0] = x8 ^ x4 ^ x2;
                m[j][1] = x8 ^ t[4 * c + j];
                m[j][2] = x8 ^ x4 ^ t[4 * c + j];
                m[j][3] = x8 ^ x2 ^ t[4 * c + j];
            end
            // Inverse MixColumns row r uses 14, 11, 13, 9 rotated by r.
            for (int row = 0; row < 4; row++)
                r[127 - 8 * (4 * c + row) -: 8] = mix ?
                    (m[0][row & 3] ^ m[1][(row + 3) & 3] ^
                     m[2][(row + 2) & 3] ^ m[3][(row + 1) & 3]) : t[4 * c + row];
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            buf_block[127 - 8 * i -: 8] = buf_mem[i];
    end

    assign plain = st_reg ^ chain_reg;

    always_comb
    begin
        lim_eff = (pos_reg == '0 && !ovf_reg) ? tpl_config[7:4] : limit_reg;
        if (pos_reg >= POS_W'(FRAME_MAX))
            cls = CLS_DROP;
        else if (pos_reg < POS_W'(HEADER_LEN))
            cls = CLS_SINGLE;
        else if (lim_eff == '0 || done_reg < {1'b0, lim_eff})
            cls = CLS_BUFFER;
        else
            cls = CLS_SINGLE;
    end

    always_comb
    begin
        if (ovf_reg)
            fst = ST_FRAME_LONG;
        else if (pos_reg <= POS_W'(HEADER_LEN))
            fst = ST_FRAME_SHORT;
        else if (done_reg == '0)
            fst = ST_PAYLOAD_SHORT;
        else
            fst = ST_OK;
    end

    always_comb
    begin
        case (cmd.sel)
            EM_SINGLE:
            begin
                em_byte = byte_reg;
                em_dec  = 1'b0;
            end
            EM_BLOCK:
            begin
                em_byte = st_reg[127 - 8 * cmd.idx -: 8];
                em_dec  = 1'b1;
            end
            EM_FLUSH:
            begin
                em_byte = buf_mem[cmd.idx];
                em_dec  = 1'b0;
            end
            default:
            begin
                em_byte = '0;
                em_dec  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sts.in_valid  = in_valid;
        sts.in_last   = last_byte;
        sts.cls       = cls;
        sts.blk_full  = (fill_reg == 4'd15);
        sts.fill_nz   = (fill_reg != '0);
        sts.fill_last = fill_reg - 4'd1;
        sts.last      = last_reg;
        sts.out_free  = !out_valid_reg || !out_stall;
        sts.key_ready = key_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            limit_reg     <= '0;
            done_reg      <= '0;
            fill_reg      <= '0;
            check_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                last_reg  <= last_byte;
                limit_reg <= lim_eff;
                case (cls)
                    CLS_DROP:
                        ovf_reg <= 1'b1;
                    CLS_SINGLE:
                    begin
                        pos_reg <= pos_reg + POS_W'(1);
                        for (int k = 0; k < 8; k++)
                            if (pos_reg == POS_W'(k + 2))
                                chain_reg[127 - 8 * k -: 8] <= frame_byte;
                        if (pos_reg == POS_W'(11))
                            chain_reg[63:0] <= {8{frame_byte}};
                    end
                    default:
                    begin
                        pos_reg  <= pos_reg + POS_W'(1);
                        fill_reg <= fill_reg + 4'd1;
                    end
                endcase
            end
            if (cmd.aes_finish)
            begin
                chain_reg <= buf_block;
                if (done_reg == '0)
                    check_reg <= (plain[127:120] == CHECK_BYTE)
                                 && (plain[119:112] == CHECK_BYTE);
                if (done_reg != 5'd31)
                    done_reg <= done_reg + 5'd1;
                fill_reg <= '0;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.clear)
            begin
                pos_reg   <= '0;
                limit_reg <= '0;
                done_reg  <= '0;
                fill_reg  <= '0;
                check_reg <= 1'b0;
                ovf_reg   <= 1'b0;
                chain_reg <= '0;
            end
        end
    end

    // The finish step folds the chain into the state, so the output beats
    // read plaintext while the chain already holds this block's ciphertext.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= frame_byte;
            if (cls == CLS_BUFFER)
                buf_mem[fill_reg] <= frame_byte;
        end
        if (cmd.aes_load)
            st_reg <= buf_block ^ rk_word;
        else if (cmd.aes_round)
            st_reg <= inv_round(st_reg, rk_word, cmd.rk_idx != '0);
        else if (cmd.aes_finish)
            st_reg <= plain;
        if (cmd.emit)
        begin
            out_byte_reg   <= em_byte;
            out_dec_reg    <= em_dec;
            out_end_reg    <= cmd.end_frame;
            out_status_reg <= cmd.end_frame ? fst : ST_OK;
            out_check_reg  <= cmd.end_frame && fst == ST_OK && check_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign was_decrypted  = out_dec_reg;
    assign frame_end      = out_end_reg;
    assign status         = out_status_reg;
    assign check_bytes_ok = out_check_reg;

endmodule

### rtl/mfad_ctrl.sv
// ----------------------------------------------------------------------------
// mfad_ctrl: sequencer of the mode 5 frame decryptor
// Takes one byte, then steps the datapath through the decryption rounds
// and the output beats that the byte causes.
// ----------------------------------------------------------------------------
module mfad_ctrl
    import mfad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mfad_sts_t sts,
    output mfad_cmd_t cmd,
    output logic      in_stall
);

    typedef enum logic [2:0] {
        S_IDLE, S_SINGLE, S_KEYWAIT, S_ROUND, S_FINISH, S_BLOCK, S_FLUSH, S_DUMMY
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sel    = EM_SINGLE;
        cmd.idx    = cnt_reg;
        cmd.rk_idx = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = sts.in_valid;
                cnt_next   = '0;
                if (sts.in_valid)
                begin
                    case (sts.cls)
                        CLS_DROP:
                            if (sts.in_last)
                                state_next = sts.fill_nz ? S_FLUSH : S_DUMMY;
                        CLS_SINGLE:
                            state_next = S_SINGLE;
                        default:
                            if (sts.blk_full)
                                state_next = S_KEYWAIT;
                            else if (sts.in_last)
                                state_next = S_FLUSH;
                    endcase
                end
            end
            S_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.end_frame = sts.last && !sts.fill_nz;
                    cmd.clear     = cmd.end_frame;
                    state_next    = (sts.last && sts.fill_nz) ? S_FLUSH : S_IDLE;
                end
            end
            S_KEYWAIT:
            begin
                cmd.rk_idx = 4'd10;
                if (sts.key_ready)
                begin
                    cmd.aes_load = 1'b1;
                    cnt_next     = 4'd9;
                    state_next   = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.aes_round = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_FINISH;
                else
                    cnt_next = cnt_reg - 4'd1;
            end
            S_FINISH:
            begin
                cmd.aes_finish = 1'b1;
                cnt_next       = '0;
                state_next     = S_BLOCK;
            end
            S_BLOCK:
            begin
                cmd.sel = EM_BLOCK;
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.end_frame = sts.last && cnt_reg == 4'd15;
                    cmd.clear     = cmd.end_frame;
                    cnt_next      = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                cmd.sel = EM_FLUSH;
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.end_frame = (cnt_reg == sts.fill_last);
                    cmd.clear     = cmd.end_frame;
                    cnt_next      = cnt_reg + 4'd1;
                    if (cmd.end_frame)
                        state_next = S_IDLE;
                end
            end
            S_DUMMY:
            begin
                cmd.sel = EM_DUMMY;
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.end_frame = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // The round keys must not change while a block is being decrypted.
    a_keys_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |-> sts.key_ready)
        else $error("round keys changed during decryption");

    // A result is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an untaken result");

    // The CBC finish step always follows the last round.
    a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH |-> $past(state_reg) == S_ROUND && $past(cnt_reg) == '0)
        else $error("finish step out of order");

endmodule

### rtl/mode5_frame_aes_cbc_decryptor.sv
// ----------------------------------------------------------------------------
// mode5_frame_aes_cbc_decryptor: wireless meter mode 5 frame decryptor
// Byte-wide AES-128-CBC decryption of frame payloads with header
// pass-through and a per-frame status on the last result.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the input channel (in_valid / in_stall) one transfer
// per byte, with tpl_config sampled on the first byte and last_byte on the
// final one. Results leave on the output channel (out_valid / out_stall).
// The key is written through cfg_we / cfg_index / cfg_data (index 0 upper
// half, index 1 lower half) while the block is idle.
// A header or raw byte is registered and then loaded into the output
// register once the output is free; the next byte is taken only after that,
// so such bytes do not overlap. The sixteenth byte of a block starts one
// inverse AES round per cycle in the iterative round unit: a load step, ten
// rounds, one CBC step, then sixteen output beats.
// After reset, and after every key write, the key expander rebuilds the
// round keys; a block waits for it if needed.
// Reset clears the frame state and the output valid flag. When the receiver
// stalls, the output holds its result and a pending result stalls the input.
// ----------------------------------------------------------------------------
module mode5_frame_aes_cbc_decryptor
    import mfad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  frame_byte,
    input  logic [15:0] tpl_config,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        was_decrypted,
    output logic        frame_end,
    output logic [1:0]  status,
    output logic        check_bytes_ok
);

    mfad_cmd_t    cmd;
    mfad_sts_t    sts;
    logic [127:0] rk_word;
    logic         key_ready;

    // Round keys are rebuilt after each key write and served by round.
    mfad_keyexp u_keyexp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rk_idx    (cmd.rk_idx),
        .rk_word   (rk_word),
        .key_ready (key_ready)
    );

    // The controller sequences each transfer; the datapath does the work.
    mfad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    mfad_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_valid       (in_valid),
        .frame_byte     (frame_byte),
        .tpl_config     (tpl_config),
        .last_byte      (last_byte),
        .rk_word        (rk_word),
        .key_ready      (key_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .was_decrypted  (was_decrypted),
        .frame_end      (frame_end),
        .status         (status),
        .check_bytes_ok (check_bytes_ok)
    );

endmodule
